@@ rtl/thsq_pkg.sv @@
// ---------------------------------------------------------------------------
// thsq_pkg: shared types and constants
// Field widths, register indexes, lane commands and result layouts for the
// three-axis homing sequencer.
// ---------------------------------------------------------------------------
package thsq_pkg;

	localparam int AXES        = 3;
	localparam int TIMEOUT_W   = 16;
	localparam int MAX_STEPS_W = 20;
	localparam int ELAPSED_W   = 17;
	localparam int MS_W        = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 20;

	localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 16'd10000;
	localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RST = 20'd20000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT_MS = 1'b0,
		CFG_MAX_STEPS  = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_ESTOP,
		CMD_STEP,
		CMD_TIMEOUT
	} lane_cmd_t;

	typedef struct packed {
		logic pulse;
		logic moving;
		logic homed;
	} lane_res_t;

	typedef struct packed {
		logic [AXES-1:0] step;
		logic            busy;
		logic            done;
		logic [AXES-1:0] homed;
		logic            all_homed;
	} result_t;

endpackage

@@ rtl/thsq_req_if.sv @@
// ---------------------------------------------------------------------------
// thsq_req_if: request channel
// Valid/ready channel carrying one start or step request.
// ---------------------------------------------------------------------------
interface thsq_req_if;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic                     limit_x;
	logic                     limit_y;
	logic                     limit_z;
	logic                     estop;
	logic [thsq_pkg::MS_W-1:0] ms_delta;

	modport source (output valid, req_type, limit_x, limit_y, limit_z, estop, ms_delta,
		input ready);
	modport sink (input valid, req_type, limit_x, limit_y, limit_z, estop, ms_delta,
		output ready);
endinterface

@@ rtl/thsq_res_if.sv @@
// ---------------------------------------------------------------------------
// thsq_res_if: result channel
// Valid/ready channel carrying the step pulses and the homing report.
// ---------------------------------------------------------------------------
interface thsq_res_if;
	logic valid;
	logic ready;
	logic step_x;
	logic step_y;
	logic step_z;
	logic busy_res;
	logic done_res;
	logic x_homed;
	logic y_homed;
	logic z_homed;
	logic all_homed;

	modport source (output valid, step_x, step_y, step_z, busy_res, done_res,
		x_homed, y_homed, z_homed, all_homed, input ready);
	modport sink (input valid, step_x, step_y, step_z, busy_res, done_res,
		x_homed, y_homed, z_homed, all_homed, output ready);
endinterface

@@ rtl/thsq_cfg_if.sv @@
// ---------------------------------------------------------------------------
// thsq_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface thsq_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [thsq_pkg::CFG_IDX_W-1:0]  index;
	logic [thsq_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/thsq_axis_lane.sv @@
// ---------------------------------------------------------------------------
// thsq_axis_lane: one axis of the homing run
// Holds the moving and failed flags and the saturating step counter of one
// axis, and reports its pulse, next moving flag and homed flag.
// ---------------------------------------------------------------------------
module thsq_axis_lane #(
	parameter int STEP_COUNT_BITS = 21
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  thsq_pkg::lane_cmd_t                  cmd,
	input  logic                                 lim,
	input  logic [thsq_pkg::MAX_STEPS_W-1:0]     max_steps,
	output thsq_pkg::lane_res_t                  lane_res
);

	localparam int CMP_W = (STEP_COUNT_BITS > thsq_pkg::MAX_STEPS_W) ?
		STEP_COUNT_BITS : thsq_pkg::MAX_STEPS_W;

	logic                       moving_q;
	logic                       failed_q;
	logic [STEP_COUNT_BITS-1:0] cnt_q;
	logic [STEP_COUNT_BITS-1:0] cnt_nxt;
	logic                       over;
	logic                       mov_nxt;

	always_comb begin
		cnt_nxt = cnt_q;
		if (moving_q && (cnt_q != {STEP_COUNT_BITS{1'b1}})) begin
			cnt_nxt = cnt_q + {{(STEP_COUNT_BITS-1){1'b0}}, 1'b1};
		end
		over    = CMP_W'(cnt_nxt) > CMP_W'(max_steps);
		mov_nxt = moving_q & ~lim & ~over;
		lane_res.pulse  = moving_q;
		lane_res.moving = mov_nxt;
		lane_res.homed  = lim & ~(failed_q | over);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q <= 1'b0;
			failed_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			case (cmd)
				thsq_pkg::CMD_START: begin
					cnt_q    <= '0;
					moving_q <= ~lim;
					failed_q <= 1'b0;
				end
				thsq_pkg::CMD_ESTOP: begin
					moving_q <= 1'b0;
				end
				thsq_pkg::CMD_STEP: begin
					cnt_q    <= cnt_nxt;
					failed_q <= failed_q | over;
					moving_q <= mov_nxt;
				end
				thsq_pkg::CMD_TIMEOUT: begin
					cnt_q    <= cnt_nxt;
					failed_q <= ~lim;
					moving_q <= 1'b0;
				end
				default: begin
					moving_q <= moving_q;
				end
			endcase
		end
	end

endmodule

@@ rtl/thsq_merge.sv @@
// ---------------------------------------------------------------------------
// thsq_merge: run control and lane merge
// Tracks the running flag and elapsed time, combines the three lane reports
// into one result and issues the command that every lane applies.
// ---------------------------------------------------------------------------
module thsq_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic                               req_type,
	input  logic                               estop,
	input  logic [thsq_pkg::AXES-1:0]          lim,
	input  logic [thsq_pkg::MS_W-1:0]          ms_delta,
	input  logic [thsq_pkg::TIMEOUT_W-1:0]     timeout_ms,
	input  thsq_pkg::lane_res_t [thsq_pkg::AXES-1:0] lane_res,
	output thsq_pkg::lane_cmd_t                cmd,
	output thsq_pkg::result_t                  result
);

	localparam int EW = thsq_pkg::ELAPSED_W;

	logic                       running_q;
	logic [EW-1:0]              elapsed_q;
	logic [EW:0]                sum;
	logic [EW-1:0]              elapsed_nxt;
	logic                       timeout;
	logic [thsq_pkg::AXES-1:0]  pulses;
	logic [thsq_pkg::AXES-1:0]  mov_all;
	logic [thsq_pkg::AXES-1:0]  homed_all;
	thsq_pkg::lane_cmd_t        cmd_c;

	always_comb begin
		sum         = {1'b0, elapsed_q} + (EW+1)'(ms_delta);
		elapsed_nxt = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
		timeout     = elapsed_nxt > EW'(timeout_ms);
		for (int a = 0; a < thsq_pkg::AXES; a++) begin
			pulses[a]    = lane_res[a].pulse;
			mov_all[a]   = lane_res[a].moving;
			homed_all[a] = lane_res[a].homed;
		end
	end

	always_comb begin
		cmd_c  = thsq_pkg::CMD_NONE;
		result = '0;
		if (req_type == thsq_pkg::REQ_START) begin
			cmd_c = thsq_pkg::CMD_START;
			if (&lim) begin
				// every axis already sits on its switch
				result.done      = 1'b1;
				result.homed     = estop ? '0 : lim;
				result.all_homed = ~estop;
			end else begin
				result.busy = 1'b1;
			end
		end else if (running_q) begin
			if (estop) begin
				cmd_c       = thsq_pkg::CMD_ESTOP;
				result.done = 1'b1;
			end else if (timeout) begin
				cmd_c            = thsq_pkg::CMD_TIMEOUT;
				result.step      = pulses;
				result.done      = 1'b1;
				result.homed     = lim;
				result.all_homed = &lim;
			end else begin
				cmd_c       = thsq_pkg::CMD_STEP;
				result.step = pulses;
				if (mov_all == '0) begin
					result.done      = 1'b1;
					result.homed     = homed_all;
					result.all_homed = &homed_all;
				end else begin
					result.busy = 1'b1;
				end
			end
		end
		cmd = accept ? cmd_c : thsq_pkg::CMD_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			elapsed_q <= '0;
		end else if (accept) begin
			case (cmd_c)
				thsq_pkg::CMD_START: begin
					running_q <= ~(&lim);
					elapsed_q <= '0;
				end
				thsq_pkg::CMD_ESTOP: begin
					running_q <= 1'b0;
				end
				thsq_pkg::CMD_TIMEOUT: begin
					running_q <= 1'b0;
					elapsed_q <= elapsed_nxt;
				end
				thsq_pkg::CMD_STEP: begin
					running_q <= |mov_all;
					elapsed_q <= elapsed_nxt;
				end
				default: begin
					running_q <= running_q;
				end
			endcase
		end
	end

endmodule

@@ rtl/three_axis_homing_sequencer.sv @@
// ---------------------------------------------------------------------------
// three_axis_homing_sequencer: three-axis limit switch homing
// Homes X, Y and Z toward their limit switches in parallel, one lane per
// axis, with a merge stage that forms the per-item pulses and report.
// ---------------------------------------------------------------------------
//
//  channel | modport | contents
//  --------+---------+-------------------------------------------------
//  req     | sink    | req_type, limit_x/y/z, estop, ms_delta
//  res     | source  | step_x/y/z, busy_res, done_res, x/y/z_homed, all_homed
//  cfg     | sink    | index (0 timeout_ms, 1 max_steps), data
//
//  One request per cycle unless a stalled result blocks it: every lane and
//  the merge stage settle a whole request in the accepting cycle, and the
//  result appears in the output register on the next cycle.
//  Reset clears the run state and loads timeout_ms = 10000, max_steps = 20000.
//  A stalled result holds in the output register; req.ready stays high
//  whenever that register is empty or being taken in the same cycle.
//  Configuration writes are always ready and take effect on the next cycle.
// ---------------------------------------------------------------------------
module three_axis_homing_sequencer #(
	parameter int STEP_COUNT_BITS = 21
) (
	input  logic      clk,
	input  logic      arst_n,
	thsq_req_if.sink  req,
	thsq_res_if.source res,
	thsq_cfg_if.sink  cfg
);

	logic [thsq_pkg::TIMEOUT_W-1:0]          timeout_q;
	logic [thsq_pkg::MAX_STEPS_W-1:0]        max_steps_q;
	logic                                    res_valid_q;
	thsq_pkg::result_t                       res_data_q;
	logic                                    accept;
	logic [thsq_pkg::AXES-1:0]               lim;
	thsq_pkg::lane_cmd_t                     cmd;
	thsq_pkg::lane_res_t [thsq_pkg::AXES-1:0] lane_res;
	thsq_pkg::result_t                       result;

	// Take a new request whenever the output register frees up this cycle.
	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;
	assign lim       = {req.limit_z, req.limit_y, req.limit_x};

	// Configuration registers: no backpressure on writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= thsq_pkg::TIMEOUT_RST;
			max_steps_q <= thsq_pkg::MAX_STEPS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				thsq_pkg::CFG_TIMEOUT_MS: timeout_q   <= cfg.data[thsq_pkg::TIMEOUT_W-1:0];
				thsq_pkg::CFG_MAX_STEPS:  max_steps_q <= cfg.data[thsq_pkg::MAX_STEPS_W-1:0];
				default: begin
					timeout_q <= timeout_q;
				end
			endcase
		end
	end

	// One lane per axis: counter, moving and failed flags.
	for (genvar a = 0; a < thsq_pkg::AXES; a++) begin : g_lane
		thsq_axis_lane #(
			.STEP_COUNT_BITS (STEP_COUNT_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.lim       (lim[a]),
			.max_steps (max_steps_q),
			.lane_res  (lane_res[a])
		);
	end

	// Merge the lane reports, track time, and decide what the lanes apply.
	thsq_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req.req_type),
		.estop      (req.estop),
		.lim        (lim),
		.ms_delta   (req.ms_delta),
		.timeout_ms (timeout_q),
		.lane_res   (lane_res),
		.cmd        (cmd),
		.result     (result)
	);

	// Output register: load on accept, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_data_q <= result;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.step_x    = res_data_q.step[0];
	assign res.step_y    = res_data_q.step[1];
	assign res.step_z    = res_data_q.step[2];
	assign res.busy_res  = res_data_q.busy;
	assign res.done_res  = res_data_q.done;
	assign res.x_homed   = res_data_q.homed[0];
	assign res.y_homed   = res_data_q.homed[1];
	assign res.z_homed   = res_data_q.homed[2];
	assign res.all_homed = res_data_q.all_homed;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: three-axis homing sequencer testbench
// Drives start and step requests through the request channel and checks
// every result against a cycle-free model of the homing run kept in the
// bench. It runs a directed part first and then random homing runs under
// several register settings and handshake idling patterns.
// ---------------------------------------------------------------------------
module tb;
	import thsq_pkg::*;

	localparam int STEP_BITS      = 21;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLDOFF_CYCLES = 64;
	localparam int MAX_REPORTS    = 10;

	localparam logic [STEP_BITS-1:0] STEP_SAT    = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

	// One request as the bench sees it; bit 0 of sw is the x switch.
	typedef struct packed {
		req_kind_t       kind;
		logic [AXES-1:0] sw;
		logic            stop;
		logic [MS_W-1:0] dms;
	} homing_req_t;

	logic clk;
	logic arst_n;

	thsq_req_if req();
	thsq_res_if res();
	thsq_cfg_if cfg();

	three_axis_homing_sequencer #(
		.STEP_COUNT_BITS(STEP_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res),
		.cfg(cfg)
	);

	// Request transactions waiting for the driver, and the results the
	// homing model has worked out for requests already accepted.
	homing_req_t queued_requests[$];
	result_t     predicted_results[$];

	int mismatches     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_req    = 0;
	int holdoff_ack    = 0;
	int holdoff_left   = 0;
	int quiet_cycles   = 0;

	// Homing model: register copies (written by the stimulus process only)
	// and run state (written by the monitor only).
	logic [TIMEOUT_W-1:0]   timeout_lim   = TIMEOUT_RST;
	logic [MAX_STEPS_W-1:0] max_steps_lim = MAX_STEPS_RST;
	logic                   run_active    = 1'b0;
	logic [AXES-1:0]        moving_ax     = '0;
	logic [AXES-1:0]        failed_ax     = '0;
	logic [AXES-1:0]        sw_latched    = '0;
	logic [STEP_BITS-1:0]   step_cnt [AXES] = '{default: '0};
	logic [ELAPSED_W-1:0]   elapsed       = '0;

	// Advance the homing model by one accepted request and return the
	// result the block must produce for it.
	function automatic result_t predict_homing(homing_req_t r);
		result_t            out;
		logic [AXES-1:0]    homed_ax;
		logic [ELAPSED_W:0] sum;
		logic               finished;
		logic               aborted;
		out      = '0;
		finished = 1'b0;
		aborted  = 1'b0;
		if (r.kind == REQ_START) begin
			// Start always begins from scratch, even in the middle of a run.
			run_active = 1'b0;
			failed_ax  = '0;
			elapsed    = '0;
			foreach (step_cnt[a]) step_cnt[a] = '0;
			sw_latched = r.sw;
			moving_ax  = ~r.sw;
			if (moving_ax == '0) begin
				// Every axis already sits on its switch: report at once.
				finished = 1'b1;
				aborted  = r.stop;
			end else begin
				run_active = 1'b1;
				out.busy   = 1'b1;
			end
		end else if (run_active) begin
			if (r.stop) begin
				finished = 1'b1;
				aborted  = 1'b1;
			end else begin
				out.step = moving_ax;
				foreach (step_cnt[a]) begin
					if (moving_ax[a] && step_cnt[a] != STEP_SAT)
						step_cnt[a] = step_cnt[a] + 1'b1;
				end
				sw_latched = r.sw;
				moving_ax  = moving_ax & ~r.sw;
				sum        = {1'b0, elapsed} + (ELAPSED_W+1)'(r.dms);
				elapsed    = (sum > {1'b0, ELAPSED_SAT}) ? ELAPSED_SAT : sum[ELAPSED_W-1:0];
				if (elapsed > ELAPSED_W'(timeout_lim)) begin
					// Timeout overrides any earlier step limit verdict.
					failed_ax = ~sw_latched;
					finished  = 1'b1;
				end else begin
					// Step limit applies even to an axis that just hit its switch.
					foreach (step_cnt[a]) begin
						if (step_cnt[a] > STEP_BITS'(max_steps_lim)) begin
							failed_ax[a] = 1'b1;
							moving_ax[a] = 1'b0;
						end
					end
					if (moving_ax == '0)
						finished = 1'b1;
					else
						out.busy = 1'b1;
				end
			end
		end
		if (finished) begin
			homed_ax      = aborted ? '0 : (sw_latched & ~failed_ax);
			run_active    = 1'b0;
			moving_ax     = '0;
			out.done      = 1'b1;
			out.homed     = homed_ax;
			out.all_homed = &homed_ax;
		end
		return out;
	endfunction

	// Clock from time zero; reset and input values are set in the main stimulus block.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Driver: hold the current transaction until it is taken, then advance
	// to the next queued request unless the sender idles this cycle.
	always @(posedge clk) begin
		homing_req_t nxt;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req.ready) begin
			if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = queued_requests.pop_front();
				req.valid    <= 1'b1;
				req.req_type <= nxt.kind;
				req.limit_x  <= nxt.sw[0];
				req.limit_y  <= nxt.sw[1];
				req.limit_z  <= nxt.sw[2];
				req.estop    <= nxt.stop;
				req.ms_delta <= nxt.dms;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor: check the result transaction first, then predict for the
	// request transaction of the same edge, so the queue order never
	// depends on process scheduling. Also drive the receiver's ready.
	always @(posedge clk) begin
		homing_req_t seen;
		result_t     got;
		result_t     want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				got.step      = {res.step_z, res.step_y, res.step_x};
				got.busy      = res.busy_res;
				got.done      = res.done_res;
				got.homed     = {res.z_homed, res.y_homed, res.x_homed};
				got.all_homed = res.all_homed;
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result with nothing pending: %p", $realtime, got);
				end else begin
					want = predicted_results.pop_front();
					if (got.step !== want.step || got.busy !== want.busy ||
						got.done !== want.done || got.homed !== want.homed ||
						got.all_homed !== want.all_homed) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"%0t: mismatch: expected step=%b busy=%b done=%b homed=%b ",
								"all=%b, got step=%b busy=%b done=%b homed=%b all=%b"},
								$realtime, want.step, want.busy, want.done, want.homed,
								want.all_homed, got.step, got.busy, got.done, got.homed,
								got.all_homed);
					end
				end
			end
			if (req.valid && req.ready) begin
				seen.kind = req_kind_t'(req.req_type);
				seen.sw   = {req.limit_z, req.limit_y, req.limit_x};
				seen.stop = req.estop;
				seen.dms  = req.ms_delta;
				predicted_results.push_back(predict_homing(seen));
			end
			// A new hold-off request restarts the long receiver stall.
			if (holdoff_ack != holdoff_req) begin
				holdoff_ack  = holdoff_req;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: drop the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready) ||
			(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_req(input req_kind_t kind, input logic [AXES-1:0] sw,
		input logic stop, input logic [MS_W-1:0] dms);
		homing_req_t r;
		r.kind = kind;
		r.sw   = sw;
		r.stop = stop;
		r.dms  = dms;
		queued_requests.push_back(r);
	endtask

	// Mostly short time slices, now and then anything up to the field max.
	function automatic logic [MS_W-1:0] rand_dms();
		return MS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, 7));
	endfunction

	// Queue well-formed homing runs (a start, then steps with switches that
	// close and stay closed, with rare glitches and emergency stops), mixed
	// with stray requests of any shape.
	task automatic add_homing_runs(input int n_items, input int max_run);
		int              added;
		int              steps;
		logic [AXES-1:0] reached;
		logic [AXES-1:0] glitch;
		added = 0;
		while (added < n_items) begin
			if ($urandom_range(0, 7) == 0) begin
				push_req(req_kind_t'($urandom_range(0, 1)), AXES'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)), MS_W'($urandom_range(0, 255)));
				added++;
			end else begin
				reached = ($urandom_range(0, 5) == 0) ? AXES'($urandom_range(0, 7)) : '0;
				push_req(REQ_START, reached, $urandom_range(0, 15) == 0, rand_dms());
				steps = $urandom_range(1, max_run);
				added += steps + 1;
				repeat (steps) begin
					for (int a = 0; a < AXES; a++) begin
						if ($urandom_range(0, 9) == 0)
							reached[a] = 1'b1;
					end
					glitch = ($urandom_range(0, 15) == 0) ? AXES'($urandom_range(0, 7)) : '0;
					push_req(REQ_STEP, reached ^ glitch, $urandom_range(0, 39) == 0,
						rand_dms());
				end
			end
		end
	endtask

	// Wait until every queued request is accepted and every result is back,
	// then let the output register settle before returning.
	task automatic wait_idle();
		do @(negedge clk);
		while (queued_requests.size() != 0 || req.valid || predicted_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_TIMEOUT_MS: timeout_lim   = val[TIMEOUT_W-1:0];
			CFG_MAX_STEPS:  max_steps_lim = val[MAX_STEPS_W-1:0];
			default: ;
		endcase
	endtask

	// Drain, load both registers, pick the idling pattern, queue the runs.
	task automatic run_phase(input logic [TIMEOUT_W-1:0] tmo,
		input logic [MAX_STEPS_W-1:0] lim, input int s_pct, input int r_pct,
		input int n_items, input int max_run, input bit holdoff);
		wait_idle();
		write_reg(CFG_TIMEOUT_MS, CFG_DATA_W'(tmo));
		write_reg(CFG_MAX_STEPS, lim);
		@(negedge clk);
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		if (holdoff)
			holdoff_req++;
		add_homing_runs(n_items, max_run);
	endtask

	initial begin
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.req_type = REQ_START;
		req.limit_x  = 1'b0;
		req.limit_y  = 1'b0;
		req.limit_z  = 1'b0;
		req.estop    = 1'b0;
		req.ms_delta = '0;
		res.ready    = 1'b0;
		cfg.valid    = 1'b0;
		cfg.index    = CFG_TIMEOUT_MS;
		cfg.data     = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part on the reset register values.
		push_req(REQ_STEP,  3'b111, 1'b1, 8'hFF);  // step while idle, all fields high
		push_req(REQ_STEP,  3'b000, 1'b0, 8'h00);  // step while idle, all fields low
		push_req(REQ_START, 3'b111, 1'b0, 8'h00);  // every axis already home
		push_req(REQ_START, 3'b111, 1'b1, 8'hFF);  // already home under emergency stop
		push_req(REQ_START, 3'b000, 1'b0, 8'hFF);
		push_req(REQ_STEP,  3'b001, 1'b0, 8'hFF);  // x reaches its switch
		push_req(REQ_STEP,  3'b011, 1'b0, 8'h80);  // y reaches its switch
		push_req(REQ_START, 3'b010, 1'b0, 8'h01);  // restart in the middle of a run
		push_req(REQ_STEP,  3'b000, 1'b1, 8'h7F);  // emergency stop on a step
		push_req(REQ_STEP,  3'b111, 1'b0, 8'h10);  // idle again after the abort
		push_req(REQ_START, 3'b000, 1'b0, 8'h00);
		push_req(REQ_STEP,  3'b111, 1'b0, 8'hFF);  // all axes home together

		// Tight limits: step limit failure, then a timeout.
		wait_idle();
		write_reg(CFG_TIMEOUT_MS, 20'd20);
		write_reg(CFG_MAX_STEPS, 20'd2);
		@(negedge clk);
		push_req(REQ_START, 3'b100, 1'b0, 8'h00);
		push_req(REQ_STEP,  3'b000, 1'b0, 8'h05);
		push_req(REQ_STEP,  3'b001, 1'b0, 8'h05);
		push_req(REQ_STEP,  3'b011, 1'b0, 8'h05);  // y over the limit as it hits its switch
		push_req(REQ_START, 3'b000, 1'b0, 8'h00);
		push_req(REQ_STEP,  3'b000, 1'b0, 8'h0A);
		push_req(REQ_STEP,  3'b001, 1'b0, 8'h0A);  // elapsed equals the timeout
		push_req(REQ_STEP,  3'b001, 1'b0, 8'h01);  // one past it: timeout

		// Random runs under several settings and idling patterns.
		run_phase(16'hFFFF, 20'hFFFFF, 0, 0, 80, 24, 1'b0);
		run_phase(16'h0000, 20'h00000, 82, 0, 40, 2, 1'b0);
		run_phase(16'd200, 20'd8, 0, 82, 100, 12, 1'b0);
		run_phase(16'd60, 20'd4, 15, 15, 100, 8, 1'b0);
		run_phase(16'd1000, 20'd20, 0, 0, 100, 24, 1'b1);
		run_phase(TIMEOUT_RST, MAX_STEPS_RST, 0, 0, 80, 24, 1'b0);

		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
